@@ design/slcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types and constants of the sync/length/crc frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  // crc16 ccitt-false
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_MSB_MASK = 16'h8000;

  // configuration register indexes
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // reset values of the sync registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // control from the parser to the crc unit
  typedef struct packed {
    logic start;  // fold in one word, then shift it through bit by bit
    logic clear;  // back to the initial value
  } crc_ctrl_t;

endpackage

@@ design/slcfr_crc.sv @@
// ----------------------------------------------------------------------------
// slcfr_crc
// Bit-serial crc16 unit: one polynomial step per cycle, eight per word.
// ----------------------------------------------------------------------------
module slcfr_crc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slcfr_pkg::crc_ctrl_t  ctrl_i,
  input  logic [7:0]            data_i,
  output logic                  busy_o,
  output logic [15:0]           crc_o
);
  import slcfr_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [15:0] step_in;
  logic [15:0] step_out;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  // first step happens in the start cycle
  assign step_in  = ctrl_i.start ? (crc_q ^ {data_i, 8'h00}) : crc_q;
  assign step_out = ((step_in & CRC_MSB_MASK) != 16'h0000) ?
                    ({step_in[14:0], 1'b0} ^ CRC_POLY) : {step_in[14:0], 1'b0};

  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.clear) begin
      crc_d  = CRC_INIT;
      busy_d = 1'b0;
      cnt_d  = '0;
    end else if (ctrl_i.start) begin
      crc_d  = step_out;
      cnt_d  = 3'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = step_out;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

@@ design/slcfr_store.sv @@
// ----------------------------------------------------------------------------
// slcfr_store
// Payload buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slcfr_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sync_length_crc_frame_receiver_top.sv @@
// id, length and payload words hold off the input while the bit-serial crc unit shifts
// them; sync and crc words do not. After the last crc word the first result goes through
// the buffer read register, then the output register; each later word is read only once
// the previous result is taken. The input is held off until the last word of the frame
// sits in the output register. Reset (async, active low) returns the parser to the sync
// hunt with crc 0xFFFF and sync words 0xAA / 0x55; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver_top
// Frame receiver: sync hunt, id, length, buffered payload, crc16 check and
// replay of accepted frames as one result per payload word (one data-less result for an empty frame).
// ----------------------------------------------------------------------------
module sync_length_crc_frame_receiver_top #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       frame_valid_o,
  input  logic       frame_ready_i,
  output logic [7:0] frame_id_o,
  output logic [6:0] frame_length_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] byte_position_o,
  output logic       has_data_o,
  output logic       last_o
);
  import slcfr_pkg::*;

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned LW = $clog2(BUF_DEPTH + 1);
  localparam logic [7:0]  MAX_LEN = 8'(BUF_DEPTH);

  typedef enum logic [3:0] {
    ST_SYNC_A,
    ST_SYNC_B,
    ST_ID,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_PAYLOAD,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    sync_first_q, sync_second_q;
  logic [7:0]    held_id_q, held_id_d;
  logic [7:0]    held_len_q, held_len_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [7:0]    crc_lo_q, crc_lo_d;
  logic [AW-1:0] emit_idx_q, emit_idx_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_id_q, out_id_d;
  logic [6:0] out_len_q, out_len_d;
  logic [7:0] out_data_q, out_data_d;
  logic [5:0] out_pos_q, out_pos_d;
  logic       out_has_q, out_has_d;
  logic       out_last_q, out_last_d;

  crc_ctrl_t     crc_ctrl;
  logic          crc_busy;
  logic [15:0]   crc_value;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          rx_fire;
  logic          out_fire;
  logic          len_ok;
  logic [LW-1:0] len_fw;
  logic [LW-1:0] fill_next;
  logic [LW-1:0] emit_pos_next;
  logic          emit_last;

  slcfr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (rx_byte_i),
    .busy_o (crc_busy),
    .crc_o  (crc_value)
  );

  slcfr_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rx_ready_o = !(state_q inside {ST_EMIT_LD, ST_EMIT_HOLD}) && !crc_busy &&
                      !(state_q == ST_CRC_HI && out_valid_q);
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign out_fire   = out_valid_q && frame_ready_i;

  assign len_ok        = held_len_q <= MAX_LEN;
  assign len_fw        = held_len_q[LW-1:0];
  assign fill_next     = fill_q + LW'(1);
  assign emit_pos_next = LW'(emit_idx_q) + LW'(1);
  assign emit_last     = emit_pos_next == len_fw;

  always_comb begin
    state_d     = state_q;
    held_id_d   = held_id_q;
    held_len_d  = held_len_q;
    fill_d      = fill_q;
    crc_lo_d    = crc_lo_q;
    emit_idx_d  = emit_idx_q;
    out_valid_d = out_valid_q && !out_fire;
    out_id_d    = out_id_q;
    out_len_d   = out_len_q;
    out_data_d  = out_data_q;
    out_pos_d   = out_pos_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    crc_ctrl    = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = emit_idx_q;

    case (state_q)
      ST_SYNC_A: begin
        if (rx_fire && rx_byte_i == sync_first_q) begin
          state_d = ST_SYNC_B;
        end
      end
      ST_SYNC_B: begin
        if (rx_fire) begin
          if (rx_byte_i == sync_second_q) begin
            state_d        = ST_ID;
            crc_ctrl.clear = 1'b1;
          end else if (rx_byte_i != sync_first_q) begin
            state_d        = ST_SYNC_A;
            fill_d         = '0;
            crc_ctrl.clear = 1'b1;
          end
        end
      end
      ST_ID: begin
        if (rx_fire) begin
          held_id_d      = rx_byte_i;
          crc_ctrl.start = 1'b1;
          state_d        = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (rx_fire) begin
          held_len_d     = rx_byte_i;
          crc_ctrl.start = 1'b1;
          state_d        = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (rx_fire) begin
          fill_d = '0;
          if (rx_byte_i != 8'h00 || !len_ok) begin
            // oversized frame is dropped silently
            state_d        = ST_SYNC_A;
            crc_ctrl.clear = 1'b1;
          end else begin
            crc_ctrl.start = 1'b1;
            state_d        = (held_len_q == 8'h00) ? ST_CRC_LO : ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (rx_fire) begin
          mem_we         = 1'b1;
          crc_ctrl.start = 1'b1;
          fill_d         = fill_next;
          if (fill_next >= len_fw) begin
            state_d = ST_CRC_LO;
          end
        end
      end
      ST_CRC_LO: begin
        if (rx_fire) begin
          crc_lo_d = rx_byte_i;
          state_d  = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (rx_fire) begin
          crc_ctrl.clear = 1'b1;
          fill_d         = '0;
          state_d        = ST_SYNC_A;
          if ({rx_byte_i, crc_lo_q} == crc_value) begin
            if (held_len_q == 8'h00) begin
              // empty frame: a single word with no data
              out_valid_d = 1'b1;
              out_id_d    = held_id_q;
              out_len_d   = '0;
              out_data_d  = '0;
              out_pos_d   = '0;
              out_has_d   = 1'b0;
              out_last_d  = 1'b1;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = '0;
              emit_idx_d = '0;
              state_d    = ST_EMIT_LD;
            end
          end
        end
      end
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_id_d    = held_id_q;
        out_len_d   = 7'(held_len_q);
        out_data_d  = mem_rdata;
        out_pos_d   = 6'(emit_idx_q);
        out_has_d   = 1'b1;
        out_last_d  = emit_last;
        state_d     = emit_last ? ST_SYNC_A : ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_fire) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(emit_pos_next);
          emit_idx_d = AW'(emit_pos_next);
          state_d    = ST_EMIT_LD;
        end
      end
      default: begin
        state_d = ST_SYNC_A;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SYNC_A;
      held_id_q   <= '0;
      held_len_q  <= '0;
      fill_q      <= '0;
      crc_lo_q    <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_id_q   <= held_id_d;
      held_len_q  <= held_len_d;
      fill_q      <= fill_d;
      crc_lo_q    <= crc_lo_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_id_q   <= out_id_d;
    out_len_q  <= out_len_d;
    out_data_q <= out_data_d;
    out_pos_q  <= out_pos_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  // sync registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        REG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign frame_valid_o   = out_valid_q;
  assign frame_id_o      = out_id_q;
  assign frame_length_o  = out_len_q;
  assign data_byte_o     = out_data_q;
  assign byte_position_o = out_pos_q;
  assign has_data_o      = out_has_q;
  assign last_o          = out_last_q;

  a_no_rx_while_emitting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_LD || state_q == ST_EMIT_HOLD) |-> !rx_ready_o)
    else $error("input taken while a frame is being replayed");

  a_no_rx_while_crc_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_busy |-> !rx_ready_o)
    else $error("input taken while the crc unit is shifting");

  a_payload_starts_crc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAYLOAD && rx_fire) |=> crc_busy)
    else $error("payload word not folded into the crc");

  a_empty_frame_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && !has_data_o) |-> (last_o && frame_length_o == 7'd0))
    else $error("empty frame word malformed");

  a_position_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && has_data_o) |-> (7'(byte_position_o) < frame_length_o))
    else $error("word position beyond frame length");

  a_last_matches_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && has_data_o && last_o) |->
      (7'(byte_position_o) + 7'd1 == frame_length_o))
    else $error("last flag not on the final payload word");

endmodule

@@ verif/sync_length_crc_frame_receiver_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver_top_tb
// Feeds byte streams of well-formed, corrupted, oversized and noisy frames
// through the receiver under several sync settings and handshake gaps, and
// checks every handed-out payload word against a cycle-free frame parser.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_receiver_top_tb;
  import slcfr_pkg::*;

  localparam int BUF_DEPTH = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 32;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_ID, TAKE_LEN_LO,
    TAKE_LEN_HI, TAKE_PAYLOAD, TAKE_CRC_LO, TAKE_CRC_HI
  } parse_phase_e;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [7:0] id;
    logic [6:0] length;
    logic [7:0] data;
    logic [5:0] position;
    logic       has_data;
    logic       last;
  } frame_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = REG_SYNC_FIRST;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       rx_valid_i = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       frame_valid_o;
  logic       frame_ready_i = 1'b0;
  logic [7:0] frame_id_o;
  logic [6:0] frame_length_o;
  logic [7:0] data_byte_o;
  logic [5:0] byte_position_o;
  logic       has_data_o;
  logic       last_o;

  sync_length_crc_frame_receiver_top #(
    .BUF_DEPTH(BUF_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .frame_valid_o  (frame_valid_o),
    .frame_ready_i  (frame_ready_i),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .data_byte_o    (data_byte_o),
    .byte_position_o(byte_position_o),
    .has_data_o     (has_data_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // parser copy
  logic [7:0]   sync_first_q = SYNC_FIRST_RST;
  logic [7:0]   sync_second_q = SYNC_SECOND_RST;
  parse_phase_e rx_phase = HUNT_FIRST;
  logic [7:0]   seen_id = 8'h00;
  logic [7:0]   seen_len = 8'h00;
  logic [6:0]   fill_count = 7'd0;
  logic [7:0]   payload_copy [BUF_DEPTH];
  logic [15:0]  crc_acc = CRC_INIT;
  logic [7:0]   crc_lo_seen = 8'h00;

  frame_word_t  expected_words [$];
  logic [7:0]   pending_bytes [$];
  idle_mode_e   idle_mode = IDLE_NONE;
  logic         rx_word_taken = 1'b0;
  int           error_count = 0;
  int           bytes_queued = 0;
  int           cycle_count = 0;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = ((r & CRC_MSB_MASK) != 16'h0000) ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s mismatch: got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic restart_hunt();
    rx_phase = HUNT_FIRST;
    fill_count = 7'd0;
    crc_acc = CRC_INIT;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    frame_word_t w;
    case (rx_phase)
      HUNT_FIRST: begin
        if (b == sync_first_q) rx_phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == sync_second_q) begin
          rx_phase = TAKE_ID;
          crc_acc = CRC_INIT;
        end else if (b != sync_first_q) begin
          restart_hunt();
        end
      end
      TAKE_ID: begin
        seen_id = b;
        crc_acc = crc16_fold(crc_acc, b);
        rx_phase = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        seen_len = b;
        crc_acc = crc16_fold(crc_acc, b);
        rx_phase = TAKE_LEN_HI;
      end
      TAKE_LEN_HI: begin
        if (b != 8'h00 || seen_len > BUF_DEPTH) begin
          restart_hunt();
        end else begin
          crc_acc = crc16_fold(crc_acc, b);
          fill_count = 7'd0;
          rx_phase = (seen_len == 8'h00) ? TAKE_CRC_LO : TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        if (fill_count < BUF_DEPTH) payload_copy[fill_count[5:0]] = b;
        crc_acc = crc16_fold(crc_acc, b);
        fill_count = fill_count + 7'd1;
        if (fill_count >= seen_len) rx_phase = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        crc_lo_seen = b;
        rx_phase = TAKE_CRC_HI;
      end
      default: begin
        if ({b, crc_lo_seen} == crc_acc) begin
          if (seen_len == 8'h00) begin
            w = '{id: seen_id, length: 7'd0, data: 8'h00, position: 6'd0,
                  has_data: 1'b0, last: 1'b1};
            expected_words.push_back(w);
          end else begin
            for (int i = 0; i < seen_len; i++) begin
              w = '{id: seen_id, length: seen_len[6:0], data: payload_copy[i],
                    position: i[5:0], has_data: 1'b1, last: (i == seen_len - 1)};
              expected_words.push_back(w);
            end
          end
        end
        restart_hunt();
      end
    endcase
  endtask

  // stimulus building
  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [7:0] id, input int len, input bit bad_crc,
                            input bit repeat_sync, input int fill);
    logic [15:0] crc;
    logic [7:0]  data;
    push_byte(sync_first_q);
    if (repeat_sync) repeat ($urandom_range(1, 3)) push_byte(sync_first_q);
    push_byte(sync_second_q);
    crc = CRC_INIT;
    push_byte(id);
    crc = crc16_fold(crc, id);
    push_byte(8'(len));
    crc = crc16_fold(crc, 8'(len));
    push_byte(8'h00);
    crc = crc16_fold(crc, 8'h00);
    for (int i = 0; i < len; i++) begin
      data = (fill < 0) ? 8'($urandom) : 8'(fill);
      push_byte(data);
      crc = crc16_fold(crc, data);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
  endtask

  task automatic push_long_header(input logic [7:0] id, input logic [7:0] len_lo,
                                  input logic [7:0] len_hi);
    push_byte(sync_first_q);
    push_byte(sync_second_q);
    push_byte(id);
    push_byte(len_lo);
    push_byte(len_hi);
  endtask

  task automatic add_random_frames(input int budget);
    int start;
    int kind;
    int len;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, BUF_DEPTH) : $urandom_range(0, 8);
      if (kind < 65) begin
        push_frame(8'($urandom), len, 1'b0, 1'b0, -1);
      end else if (kind < 75) begin
        push_frame(8'($urandom), len, 1'b1, 1'b0, -1);
      end else if (kind < 85) begin
        push_frame(8'($urandom), len, 1'b0, 1'b1, -1);
      end else if (kind < 92) begin
        if ($urandom_range(0, 1) == 0) begin
          push_long_header(8'($urandom), 8'($urandom_range(BUF_DEPTH + 1, 255)), 8'h00);
        end else begin
          push_long_header(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic write_sync(input logic index, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (index == REG_SYNC_FIRST) sync_first_q = value;
    else sync_second_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || rx_valid_i || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sender and receiver side, driven on the falling edge
  always @(negedge clk_i) begin
    logic sender_idle;
    logic receiver_stall;
    sender_idle = 1'b0;
    receiver_stall = 1'b0;
    case (idle_mode)
      IDLE_SENDER:   sender_idle = ($urandom_range(0, 99) < 87);
      IDLE_RECEIVER: receiver_stall = ($urandom_range(0, 99) < 87);
      IDLE_BOTH: begin
        sender_idle = ($urandom_range(0, 99) < 6);
        receiver_stall = ($urandom_range(0, 99) < 6);
      end
      default: ;
    endcase
    if (!rx_valid_i || rx_word_taken) begin
      if (rst_ni && pending_bytes.size() != 0 && !sender_idle) begin
        rx_valid_i <= 1'b1;
        rx_byte_i <= pending_bytes.pop_front();
      end else begin
        rx_valid_i <= 1'b0;
      end
    end
    rx_word_taken = 1'b0;
    frame_ready_i <= !receiver_stall;
  end

  // acceptance on the rising edge
  always @(posedge clk_i) begin
    frame_word_t want;
    if (rx_valid_i && rx_ready_o) begin
      parse_rx_byte(rx_byte_i);
      rx_word_taken = 1'b1;
    end
    if (frame_valid_o && frame_ready_i) begin
      if (expected_words.size() == 0) begin
        report_error($sformatf("unexpected word: id %0h position %0h data %0h",
                               frame_id_o, byte_position_o, data_byte_o));
      end else begin
        want = expected_words.pop_front();
        check_field("frame_id", frame_id_o, want.id);
        check_field("frame_length", frame_length_o, want.length);
        check_field("data_byte", data_byte_o, want.data);
        check_field("byte_position", byte_position_o, want.position);
        check_field("has_data", has_data_o, want.has_data);
        check_field("last", last_o, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sync_length_crc_frame_receiver_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: noise, false sync, repeated sync, extremes, dropped frames
    idle_mode = IDLE_NONE;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(sync_first_q);
    push_byte(8'h00);
    push_frame(8'hFF, 0, 1'b0, 1'b1, -1);
    push_frame(8'h00, 1, 1'b0, 1'b0, 8'hFF);
    push_frame(8'h5A, 2, 1'b0, 1'b0, 8'h00);
    push_long_header(8'h11, 8'(BUF_DEPTH + 1), 8'h00);
    push_long_header(8'h22, 8'h02, 8'h01);
    push_frame(8'h33, 0, 1'b1, 1'b0, -1);
    wait_drained();

    // random frames, sender and receiver never idle
    add_random_frames(10);
    wait_drained();

    write_sync(REG_SYNC_FIRST, 8'h00);
    write_sync(REG_SYNC_SECOND, 8'hFF);
    idle_mode = IDLE_SENDER;
    add_random_frames(8);
    wait_drained();

    write_sync(REG_SYNC_FIRST, 8'hFF);
    write_sync(REG_SYNC_SECOND, 8'h00);
    idle_mode = IDLE_RECEIVER;
    add_random_frames(8);
    push_frame(8'($urandom), BUF_DEPTH, 1'b0, 1'b0, -1);
    wait_drained();

    // equal sync words: second match wins
    write_sync(REG_SYNC_FIRST, 8'h3C);
    write_sync(REG_SYNC_SECOND, 8'h3C);
    idle_mode = IDLE_BOTH;
    add_random_frames(10);
    wait_drained();

    write_sync(REG_SYNC_FIRST, 8'($urandom));
    write_sync(REG_SYNC_SECOND, 8'($urandom));
    idle_mode = IDLE_NONE;
    add_random_frames(8);
    wait_drained();

    if (expected_words.size() != 0) begin
      report_error($sformatf("%0d expected words never handed out", expected_words.size()));
    end
    if (error_count == 0) begin
      $display("sync_length_crc_frame_receiver_top_tb: PASS");
    end else begin
      $display("sync_length_crc_frame_receiver_top_tb: FAIL");
    end
    $finish;
  end

endmodule
